### hdl/twoi_pkg.sv
package twoi_pkg;

    // Micro-rotation count and the size of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_N       = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
    localparam int IDX_W        = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;

    // Field widths
    localparam int DELTA_W = 24;
    localparam int GAIN_W  = 24;
    localparam int POS_W   = 32;
    localparam int HEAD_W  = 16;

    // Datapath widths: vector in Q.16, angle in 2^32 units per turn (plus sign)
    localparam int VW      = 44;
    localparam int ZW      = 33;
    localparam int SPLIT   = 22;
    localparam int MA_W    = 26;
    localparam int MB_W    = 25;
    localparam int MP_W    = MA_W + MB_W;
    localparam int ACC_W   = 64;

    // Fixed-point constants
    localparam logic [MB_W-1:0] K_THIRD = MB_W'(21845);
    localparam logic [MB_W-1:0] K_RT3_3 = MB_W'(37837);
    localparam logic [MB_W-1:0] K_INV   = MB_W'(39797);

    // Control of the rotation unit
    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] idx;
    } t_cordic_ctrl;

    // Arctangent of 2^-i in 2^32 units per turn
    function automatic logic signed [ZW-1:0] atan_at(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return $signed({1'b0, v});
    endfunction

endpackage

### hdl/twoi_mul.sv
module twoi_mul (
    input  logic                                i_clk,
    input  logic signed [twoi_pkg::MA_W-1:0]    i_a,
    input  logic signed [twoi_pkg::MB_W-1:0]    i_b,
    output logic signed [twoi_pkg::MP_W-1:0]    o_p
);
    import twoi_pkg::*;

    logic signed [MP_W-1:0] r_p;

    // Shared signed multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_p <= MP_W'(i_a) * MP_W'(i_b);
    end

    assign o_p = r_p;

endmodule

### hdl/twoi_cordic.sv
module twoi_cordic (
    input  logic                            i_clk,
    input  twoi_pkg::t_cordic_ctrl          i_ctrl,
    input  logic signed [twoi_pkg::VW-1:0]  i_vx,
    input  logic signed [twoi_pkg::VW-1:0]  i_vy,
    input  logic signed [twoi_pkg::ZW-1:0]  i_z,
    output logic signed [twoi_pkg::VW-1:0]  o_vx,
    output logic signed [twoi_pkg::VW-1:0]  o_vy
);
    import twoi_pkg::*;

    logic signed [VW-1:0] r_vx;
    logic signed [VW-1:0] r_vy;
    logic signed [ZW-1:0] r_z;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [ZW-1:0] ang;

    // Shifted cross terms and table angle for the current micro-rotation
    always_comb begin
        dx  = r_vy >>> i_ctrl.idx;
        dy  = r_vx >>> i_ctrl.idx;
        ang = atan_at(5'(i_ctrl.idx));
    end

    // One micro-rotation per step; direction from the sign of the residual
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_vx <= i_vx;
            r_vy <= i_vy;
            r_z  <= i_z;
        end else if (i_ctrl.step) begin
            if (!r_z[ZW-1]) begin
                r_vx <= r_vx - dx;
                r_vy <= r_vy + dy;
                r_z  <= r_z - ang;
            end else begin
                r_vx <= r_vx + dx;
                r_vy <= r_vy - dy;
                r_z  <= r_z + ang;
            end
        end
    end

    assign o_vx = r_vx;
    assign o_vy = r_vy;

endmodule

### hdl/three_wheel_odometry_integrator.sv
// Three-wheel omni odometry integrator. Each input item carries the right,
// left and back wheel distance increments; the block turns them into a
// body-frame displacement, rotates it into the world frame by the heading
// stored before this item (quadrant turn plus a CORDIC on one shared rotation
// unit), adds it to the stored x/y pose and adds the gain-scaled wheel sum to
// the heading. One result item (x, y, heading) follows every input item.
// An item passes the states MF, MS, MH, QR, ROT (one micro-rotation per cycle
// in the rotation unit), CXL, CXH, CYL, CYH, CEND and UPD; the single shared
// multiplier forms seven products per item. The next item is taken only after
// the last has left UPD, which waits while the output register holds an untaken
// result. s_axis_tready is high only between items; a finished result waits in
// the output register and the next item can be taken meanwhile. The user must
// write heading_gain through i_cfg_we / i_cfg_wdata only while the block is
// idle (not enforced by the block); it resets to 1.0 (Q8.16).
module three_wheel_odometry_integrator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // right_delta, left_delta, back_delta
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // pose_x, pose_y, pose_heading
    input  logic        i_cfg_we,
    input  logic [twoi_pkg::GAIN_W-1:0] i_cfg_wdata
);
    import twoi_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MF, S_MS, S_MH, S_QR, S_ROT,
        S_CXL, S_CXH, S_CYL, S_CYH, S_CEND, S_UPD
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [GAIN_W-1:0]        r_gain;
    logic [POS_W-1:0]         r_acc_x;
    logic [POS_W-1:0]         r_acc_y;
    logic [HEAD_W-1:0]        r_acc_h;
    logic signed [MA_W-1:0]   r_fsum;
    logic signed [MA_W-1:0]   r_side;
    logic signed [MA_W-1:0]   r_hsum;
    logic signed [VW-1:0]     r_bx;
    logic signed [VW-1:0]     r_by;
    logic [HEAD_W-1:0]        r_dh;
    logic [IDX_W-1:0]         r_idx;
    logic signed [ACC_W-1:0]  r_cx;
    logic signed [ACC_W-1:0]  r_cy;
    logic                     r_out_valid;
    logic [79:0]              r_out_data;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MP_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]  p64;
    t_cordic_ctrl             cctl;
    logic signed [VW-1:0]     rot_vx;
    logic signed [VW-1:0]     rot_vy;
    logic signed [VW-1:0]     cvx;
    logic signed [VW-1:0]     cvy;
    logic signed [ZW-1:0]     z0;
    logic [HEAD_W-1:0]        hc;
    logic signed [MA_W-1:0]   r_in;
    logic signed [MA_W-1:0]   l_in;
    logic signed [MA_W-1:0]   b_in;
    logic                     in_acc;
    logic                     out_load;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == S_UPD) && (!r_out_valid || m_axis_tready);

    // Input fields, sign-extended to the multiplier operand width
    assign r_in = MA_W'($signed(s_axis_tdata[23:0]));
    assign l_in = MA_W'($signed(s_axis_tdata[47:24]));
    assign b_in = MA_W'($signed(s_axis_tdata[71:48]));

    // Quadrant of the stored heading and residual angle for the CORDIC
    always_comb begin
        hc = r_acc_h + HEAD_W'(16'h2000);
        z0 = ZW'($signed({1'b0, hc[13:0]}) - 15'sd8192) <<< 16;
        case (hc[15:14])
            2'd1:    begin rot_vx = -r_by; rot_vy = r_bx;  end
            2'd2:    begin rot_vx = -r_bx; rot_vy = -r_by; end
            2'd3:    begin rot_vx = r_by;  rot_vy = -r_bx; end
            default: begin rot_vx = r_bx;  rot_vy = r_by;  end
        endcase
    end

    // Operand selection for the shared multiplier
    always_comb begin
        case (r_state)
            S_MF:    begin mul_a = r_fsum; mul_b = K_THIRD; end
            S_MS:    begin mul_a = r_side; mul_b = K_RT3_3; end
            S_MH:    begin mul_a = r_hsum; mul_b = MB_W'({1'b0, r_gain}); end
            S_CXL:   begin mul_a = MA_W'({1'b0, cvx[SPLIT-1:0]}); mul_b = K_INV; end
            S_CXH:   begin mul_a = MA_W'($signed(cvx[VW-1:SPLIT])); mul_b = K_INV; end
            S_CYL:   begin mul_a = MA_W'({1'b0, cvy[SPLIT-1:0]}); mul_b = K_INV; end
            S_CYH:   begin mul_a = MA_W'($signed(cvy[VW-1:SPLIT])); mul_b = K_INV; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign p64 = ACC_W'(mul_p);

    // Rotation unit control
    always_comb begin
        cctl.load = (r_state == S_QR);
        cctl.step = (r_state == S_ROT);
        cctl.idx  = r_idx;
    end

    twoi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    twoi_cordic u_cordic (
        .i_clk  (i_clk),
        .i_ctrl (cctl),
        .i_vx   (rot_vx),
        .i_vy   (rot_vy),
        .i_z    (z0),
        .o_vx   (cvx),
        .o_vy   (cvy)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_MF;
            S_MF:    n_state = S_MS;
            S_MS:    n_state = S_MH;
            S_MH:    n_state = S_QR;
            S_QR:    n_state = S_ROT;
            S_ROT:   if (r_idx == IDX_W'(CORDIC_N - 1)) n_state = S_CXL;
            S_CXL:   n_state = S_CXH;
            S_CXH:   n_state = S_CYL;
            S_CYL:   n_state = S_CYH;
            S_CYH:   n_state = S_CEND;
            S_CEND:  n_state = S_UPD;
            S_UPD:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer, pose state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= GAIN_W'(65536);
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_h     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_gain <= i_cfg_wdata;
            if (r_state == S_ROT) r_idx <= r_idx + 1'b1;
            else                  r_idx <= '0;
            if (out_load) begin
                r_acc_x     <= r_acc_x + r_cx[63:32];
                r_acc_y     <= r_acc_y + r_cy[63:32];
                r_acc_h     <= r_acc_h + r_dh;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fsum <= l_in + r_in - (b_in <<< 1);
            r_side <= r_in - l_in;
            r_hsum <= r_in + l_in + b_in;
        end
        case (r_state)
            S_MS:    r_bx <= VW'(mul_p);
            S_MH:    r_by <= VW'(mul_p);
            S_QR:    r_dh <= mul_p[31:16];
            S_CXH:   r_cx <= p64 + ACC_W'(64'sh80000000);
            S_CYL:   r_cx <= r_cx + (p64 <<< SPLIT);
            S_CYH:   r_cy <= p64 + ACC_W'(64'sh80000000);
            S_CEND:  r_cy <= r_cy + (p64 <<< SPLIT);
            default: ;
        endcase
        if (out_load) begin
            r_out_data <= {r_acc_h + r_dh, r_acc_y + r_cy[63:32], r_acc_x + r_cx[63:32]};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("block ready right after accepting an item");

    // The micro-rotation index never passes the configured step count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_idx <= IDX_W'(CORDIC_N - 1)))
        else $error("rotation index out of range");

    // A presented result matches the stored pose
    a_out_matches_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (m_axis_tdata == {r_acc_h, r_acc_y, r_acc_x}))
        else $error("result differs from stored pose");

    // The pose only changes when a result is loaded
    a_pose_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_load |=> $stable(r_acc_h) && $stable(r_acc_x) && $stable(r_acc_y))
        else $error("pose changed without a result");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int TAIL_WAIT  = 40;     // settle time after the last result

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
    } pose_t;

    // DUT ports
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;    // right_delta, left_delta, back_delta
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;          // pose_x, pose_y, pose_heading
    logic        i_cfg_we      = 1'b0;
    logic [twoi_pkg::GAIN_W-1:0] i_cfg_wdata = '0;

    // Predicted pose state and gain
    logic [31:0] model_x       = '0;
    logic [31:0] model_y       = '0;
    logic [15:0] model_heading = '0;
    logic [23:0] model_gain    = 24'd65536;

    // Arctangent of 2^-i, 2^32 units per turn
    logic [31:0] turn_per_step [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    pose_t pending_poses [$];
    pose_t want;

    int    errors       = 0;
    int    samples_sent = 0;
    int    results_seen = 0;
    int    gain_writes  = 0;
    int    idle_cycles  = 0;
    int    stall_left   = 0;
    logic  tx_gaps_on   = 1'b1;
    logic  rx_stalls_on = 1'b1;
    logic [3:0] quad_seen = '0;

    three_wheel_odometry_integrator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short pauses, now and then a long one
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the pose by one wheel sample; returns the new pose
    function automatic pose_t integrate_sample(input logic [23:0] right_d,
                                               input logic [23:0] left_d,
                                               input logic [23:0] back_d);
        logic signed [63:0] r, l, b, vx, vy, dx, dy, tmp, ang, gain64, prod;
        logic [15:0] hc;
        logic [1:0]  quad;
        int          steps;
        pose_t       p;
        r      = {{40{right_d[23]}}, right_d};
        l      = {{40{left_d[23]}}, left_d};
        b      = {{40{back_d[23]}}, back_d};
        gain64 = {40'b0, model_gain};
        steps  = (twoi_pkg::CORDIC_STEPS < 24) ? twoi_pkg::CORDIC_STEPS : 24;

        // body displacement in Q.16
        vx = (l + r - 2 * b) * 64'sd21845;
        vy = (r - l) * 64'sd37837;

        // nearest quadrant of the old heading, residual within +-1/8 turn
        hc   = model_heading + 16'h2000;
        quad = hc[15:14];
        ang  = {50'b0, hc[13:0]};
        ang  = (ang - 64'sd8192) * 64'sd65536;
        quad_seen[quad] = 1'b1;

        case (quad)
            2'd1: begin tmp = vx; vx = -vy; vy = tmp; end
            2'd2: begin vx = -vx; vy = -vy; end
            2'd3: begin tmp = vx; vx = vy; vy = -tmp; end
            default: ;
        endcase

        for (int i = 0; i < steps; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (ang >= 0) begin
                vx  = vx - dx;
                vy  = vy + dy;
                ang = ang - $signed({32'h0, turn_per_step[i]});
            end else begin
                vx  = vx + dx;
                vy  = vy - dy;
                ang = ang + $signed({32'h0, turn_per_step[i]});
            end
        end

        // gain compensation, round half up to distance units
        vx = (vx * 64'sd39797 + 64'sd2147483648) >>> 32;
        vy = (vy * 64'sd39797 + 64'sd2147483648) >>> 32;

        prod = (r + l + b) * gain64;

        model_x       = model_x + vx[31:0];
        model_y       = model_y + vy[31:0];
        model_heading = model_heading + prod[31:16];

        p.x       = model_x;
        p.y       = model_y;
        p.heading = model_heading;
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("MISMATCH at result %0d, %s: got %h, expected %h",
                 results_seen, what, got, exp_val);
        errors++;
    endtask

    // Send one wheel sample and wait until it is taken
    task automatic send_sample(input logic [23:0] right_d, input logic [23:0] left_d,
                               input logic [23:0] back_d);
        int gap;
        gap = tx_gaps_on ? pick_pause() : 0;
        pending_poses.push_back(integrate_sample(right_d, left_d, back_d));
        samples_sent++;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {back_d, left_d, right_d};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop sending and wait for every pending pose
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [23:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        model_gain = value;
        gain_writes++;
    endtask

    // One random sample, or a short straight run; n = items sent
    task automatic random_sample(output int n);
        int          roll, base, mag;
        logic [23:0] r, l, b, m;
        roll = $urandom_range(0, 99);
        n    = 1;
        if (roll < 55) begin
            // realistic driving: similar right and left increments, small back increment
            base = $urandom_range(0, 4000) - 2000;
            r = 24'(base + int'($urandom_range(0, 600)) - 300);
            l = 24'(base + int'($urandom_range(0, 600)) - 300);
            b = 24'(int'($urandom_range(0, 4000)) - 2000);
            send_sample(r, l, b);
        end else if (roll < 75) begin
            send_sample(24'($urandom()), 24'($urandom()), 24'($urandom()));
        end else if (roll < 88) begin
            case ($urandom_range(0, 4))
                0: r = 24'h7FFFFF; 1: r = 24'h800000; 2: r = 24'h000000;
                3: r = 24'hFFFFFF; default: r = 24'h000001;
            endcase
            case ($urandom_range(0, 4))
                0: l = 24'h7FFFFF; 1: l = 24'h800000; 2: l = 24'h000000;
                3: l = 24'hFFFFFF; default: l = 24'h000001;
            endcase
            case ($urandom_range(0, 4))
                0: b = 24'h7FFFFF; 1: b = 24'h800000; 2: b = 24'h000000;
                3: b = 24'hFFFFFF; default: b = 24'h000001;
            endcase
            send_sample(r, l, b);
        end else begin
            // straight run forward or back, large steps
            mag = $urandom_range(1, 8388607);
            m   = 24'(($urandom_range(0, 1) != 0) ? mag : -mag);
            n   = 8;
            repeat (8) send_sample(m, m, -m);
        end
    endtask

    // Tests

    task automatic test_reset_state();
        send_sample(24'd0, 24'd0, 24'd0);
    endtask

    // Heading steps by exactly 1/8 turn: every quadrant and both residual ends
    task automatic test_quadrants();
        repeat (9) send_sample(24'd8192, 24'd0, 24'd0);
    endtask

    task automatic test_pure_motion();
        send_sample(24'd3000, 24'd3000, -24'd3000);   // forward
        send_sample(24'd3000, -24'd3000, 24'd0);      // sideways
        send_sample(24'd1000, 24'd1000, 24'd1000);    // spin in place
    endtask

    task automatic test_field_extremes();
        send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h800000, 24'h800000, 24'h800000);
        send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
        send_sample(24'h800000, 24'h800000, 24'h7FFFFF);
        send_sample(24'h7FFFFF, 24'h800000, 24'h000000);
        send_sample(24'h800000, 24'h7FFFFF, 24'h000000);
        send_sample(24'hFFFFFF, 24'h000001, 24'hFFFFFF);
        send_sample(24'h000000, 24'h000000, 24'h800000);
    endtask

    // Zero gain freezes the heading; full gain wraps it hard
    task automatic test_gain_extremes();
        write_gain(24'h000000);
        send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h800000, 24'h800000, 24'h800000);
        write_gain(24'hFFFFFF);
        send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_sample(24'h800000, 24'h800000, 24'h800000);
    endtask

    task automatic test_random_drive(input logic [23:0] gain, input int count);
        int sent, n;
        write_gain(gain);
        sent = 0;
        while (sent < count) begin
            random_sample(n);
            sent += n;
        end
    endtask

    // Long full-speed drive with frozen heading so x/y wrap
    task automatic test_position_wrap();
        write_gain(24'h000000);
        repeat (300) send_sample(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    endtask

    // Sender holds off until the pipeline is empty, then sends a burst
    task automatic test_drain_pauses();
        int n;
        repeat (20) begin
            wait_drained();
            repeat (5) begin
                random_sample(n);
            end
        end
    endtask

    // Receiver ready with random stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= rx_stalls_on ? pick_pause() : 0;
        end
    end

    // Result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (pending_poses.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
                end else begin
                    want = pending_poses.pop_front();
                    if (m_axis_tdata[31:0] !== want.x)
                        report_mismatch("pose_x", m_axis_tdata[31:0], want.x);
                    if (m_axis_tdata[63:32] !== want.y)
                        report_mismatch("pose_y", m_axis_tdata[63:32], want.y);
                    if (m_axis_tdata[79:64] !== want.heading)
                        report_mismatch("pose_heading", {16'h0, m_axis_tdata[79:64]},
                                        {16'h0, want.heading});
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        test_reset_state();
        test_quadrants();
        test_pure_motion();
        test_field_extremes();
        test_gain_extremes();

        // random phases with different gains and idle patterns
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        test_random_drive(24'd65536, 200);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        test_random_drive(24'hFFFFFF, 200);
        test_position_wrap();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b0;
        test_random_drive(24'($urandom_range(1, 300)), 200);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b1;
        test_random_drive(24'($urandom()), 200);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        test_drain_pauses();
        test_random_drive(24'd0, 200);
        test_random_drive(24'($urandom()), 200);

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Covered %0d wheel samples and %0d poses across %0d gain settings,",
                 samples_sent, results_seen, gain_writes);
        $display("with heading quadrants %b visited and x/y/heading wraparound.", quad_seen);
        if (errors == 0 && pending_poses.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
